@@ rtl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// Primitive codes, same encoding as the cmd field
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_SEND  = 3'd3,
		OP_READ  = 3'd4,
		OP_ACK   = 3'd5,
		OP_NACK  = 3'd6,
		OP_WAIT  = 3'd7
	} op_t;

	localparam int unsigned PHASE_W = 5;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [DELAY_W-1:0] PHASE_CYCLES_RST = 16'd100;

	// Send byte steps through three phases per bit
	localparam logic [1:0] SLOT_SCL_LOW  = 2'd0;
	localparam logic [1:0] SLOT_DATA     = 2'd1;
	localparam logic [1:0] SLOT_SCL_HIGH = 2'd2;

	// Per-cycle result of the sequencer
	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		logic              ok;
		logic [BYTE_W-1:0] rx;
	} result_t;

	// Index of the last phase of a primitive
	function automatic logic [PHASE_W-1:0] last_phase(input op_t op);
		logic [PHASE_W-1:0] r;
		case (op)
			OP_START: r = 5'd2;
			OP_SEND:  r = 5'd23;
			OP_READ:  r = 5'd15;
			default:  r = 5'd3;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Open-drain I2C master primitive engine: start, stop, send/read byte,
// ack, nack and wait ack, each built from timed bus phases.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid/in_ready, cmd, tx_byte, sda_in    sink
//  out      out_valid/out_ready, scl_out, sda_out,     source
//           busy_res, done_res, ok, rx_byte
//  cfg      cfg_valid/cfg_ready, cfg_data              sink (phase length)
//
//  One transaction per clock in each direction while the output is not stalled;
//  each input transaction is one bus-sequencer cycle and produces exactly one
//  output transaction. It passes the input register, then the state update
//  into the output register.
//  A stalled output holds the result and blocks the input register only when
//  both are full; cfg_ready is always high.
//  Reset: SCL and SDA released, engine idle, phase length 100.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  tx_byte,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        done_res,
	output logic        ok,
	output logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic                             valid_s1;
	logic [2:0]                       cmd_s1;
	logic [i2cms_pkg::BYTE_W-1:0]     tx_byte_s1;
	logic                             sda_in_s1;
	logic                             out_valid_q;
	i2cms_pkg::result_t               res_next;
	i2cms_pkg::result_t               res_q;
	logic [i2cms_pkg::DELAY_W-1:0]    phase_cycles_q;
	logic                             advance;

	// Process the registered transaction when the output slot frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cycles_q <= i2cms_pkg::PHASE_CYCLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			phase_cycles_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1     <= cmd;
			tx_byte_s1 <= tx_byte;
			sda_in_s1  <= sda_in;
		end
	end

	i2cms_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.cmd          (cmd_s1),
		.tx_byte      (tx_byte_s1),
		.sda_in       (sda_in_s1),
		.phase_cycles (phase_cycles_q),
		.res          (res_next)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = res_q.scl;
	assign sda_out   = res_q.sda;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign ok        = res_q.ok;
	assign rx_byte   = res_q.rx;

	// A held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("output overwritten while stalled");

	// A processed transaction always shows up at the output next cycle
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed transaction lost");

	// Input register full and output stalled means input is held off
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted with no room");

endmodule

@@ rtl/i2cms_step.sv @@
// ----------------------------------------------------------------------------
// i2cms_step
// Sequencer state and its update: accepts a new primitive when idle, or advances
// the active one by one timer step, whenever en is high, and returns the updated pin and status.
// ----------------------------------------------------------------------------
module i2cms_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [2:0]                     cmd,
	input  logic [i2cms_pkg::BYTE_W-1:0]   tx_byte,
	input  logic                           sda_in,
	input  logic [i2cms_pkg::DELAY_W-1:0]  phase_cycles,
	output i2cms_pkg::result_t             res
);

	i2cms_pkg::op_t                   op_q,    n_op;
	logic [i2cms_pkg::PHASE_W-1:0]    k_q,     n_k;
	logic [i2cms_pkg::DELAY_W-1:0]    dly_q,   n_dly;
	logic [i2cms_pkg::BYTE_W-1:0]     shift_q, n_shift;
	logic [i2cms_pkg::BYTE_W-1:0]     rx_q,    n_rx;
	logic [1:0]                       slot_q,  n_slot;
	logic                             scl_q,   n_scl;
	logic                             sda_q,   n_sda;
	logic                             ack_q,   n_ack;
	logic                             enter, fail, done, okv;
	logic [i2cms_pkg::DELAY_W-1:0]    dly_dec;

	assign dly_dec = dly_q - 16'd1;

	// Next state: accept, count down, sample, finish or enter next phase
	always_comb begin
		n_op    = op_q;
		n_k     = k_q;
		n_dly   = dly_q;
		n_shift = shift_q;
		n_rx    = rx_q;
		n_slot  = slot_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		enter   = 1'b0;
		fail    = 1'b0;
		done    = 1'b0;
		okv     = 1'b0;

		if (op_q == i2cms_pkg::OP_IDLE) begin
			if (cmd != i2cms_pkg::OP_IDLE) begin
				n_op    = i2cms_pkg::op_t'(cmd);
				n_k     = '0;
				n_slot  = i2cms_pkg::SLOT_SCL_LOW;
				n_shift = (i2cms_pkg::op_t'(cmd) == i2cms_pkg::OP_SEND) ? tx_byte : '0;
				n_ack   = 1'b0;
				enter   = 1'b1;
			end
		end else begin
			n_dly = dly_dec;
			if (dly_dec == '0) begin
				// end-of-phase checks and samples
				if (op_q == i2cms_pkg::OP_START) begin
					if (k_q == 5'd0 && !sda_in) fail = 1'b1;
					if (k_q == 5'd1 && sda_in)  fail = 1'b1;
				end else if (op_q == i2cms_pkg::OP_WAIT && k_q == 5'd2) begin
					n_ack = !sda_in;
				end else if (op_q == i2cms_pkg::OP_READ && k_q[0]) begin
					n_shift = {shift_q[i2cms_pkg::BYTE_W-2:0], sda_in};
				end

				if (fail) begin
					done = 1'b1;
					n_op = i2cms_pkg::OP_IDLE;
					n_k  = '0;
				end else if (k_q >= i2cms_pkg::last_phase(op_q)) begin
					done = 1'b1;
					if (op_q == i2cms_pkg::OP_START) okv = 1'b1;
					else if (op_q == i2cms_pkg::OP_WAIT) okv = n_ack;
					if (op_q == i2cms_pkg::OP_SEND || op_q == i2cms_pkg::OP_READ)
						n_scl = 1'b0;
					if (op_q == i2cms_pkg::OP_READ) n_rx = n_shift;
					n_op = i2cms_pkg::OP_IDLE;
					n_k  = '0;
				end else begin
					n_k    = k_q + 5'd1;
					n_slot = (slot_q == i2cms_pkg::SLOT_SCL_HIGH) ?
						i2cms_pkg::SLOT_SCL_LOW : slot_q + 2'd1;
					enter  = 1'b1;
				end
			end
		end

		// Pin action of the phase being entered, and phase timer load
		if (enter) begin
			case (n_op)
				i2cms_pkg::OP_START: begin
					if (n_k == 5'd0) begin
						n_scl = 1'b1;
						n_sda = 1'b1;
					end else begin
						n_sda = 1'b0;
					end
				end
				i2cms_pkg::OP_STOP: begin
					case (n_k)
						5'd0:    n_scl = 1'b0;
						5'd1:    n_sda = 1'b0;
						5'd2:    n_scl = 1'b1;
						default: n_sda = 1'b1;
					endcase
				end
				i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK, i2cms_pkg::OP_WAIT: begin
					case (n_k)
						5'd0:    n_scl = 1'b0;
						5'd1:    n_sda = (n_op != i2cms_pkg::OP_ACK);
						5'd2:    n_scl = 1'b1;
						default: n_scl = 1'b0;
					endcase
				end
				i2cms_pkg::OP_SEND: begin
					case (n_slot)
						i2cms_pkg::SLOT_SCL_LOW: n_scl = 1'b0;
						i2cms_pkg::SLOT_DATA: begin
							n_sda   = n_shift[i2cms_pkg::BYTE_W-1];
							n_shift = {n_shift[i2cms_pkg::BYTE_W-2:0], 1'b0};
						end
						default: n_scl = 1'b1;
					endcase
				end
				i2cms_pkg::OP_READ: begin
					if (n_k == 5'd0) begin
						n_sda = 1'b1;
						n_scl = 1'b0;
					end else begin
						n_scl = n_k[0];
					end
				end
				default: ;
			endcase
			n_dly = (phase_cycles == '0) ? 16'd1 : phase_cycles;
		end
	end

	// Results after this cycle's update
	always_comb begin
		res.scl  = n_scl;
		res.sda  = n_sda;
		res.busy = (n_op != i2cms_pkg::OP_IDLE);
		res.done = done;
		res.ok   = okv;
		res.rx   = n_rx;
	end

	// State registers, advanced once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= i2cms_pkg::OP_IDLE;
			k_q     <= '0;
			dly_q   <= '0;
			shift_q <= '0;
			rx_q    <= '0;
			slot_q  <= i2cms_pkg::SLOT_SCL_LOW;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
		end else if (en) begin
			op_q    <= n_op;
			k_q     <= n_k;
			dly_q   <= n_dly;
			shift_q <= n_shift;
			rx_q    <= n_rx;
			slot_q  <= n_slot;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			ack_q   <= n_ack;
		end
	end

	// A running primitive always has a live phase timer
	a_dly_live: assert property (@(posedge clk) disable iff (!arst_n)
		op_q != i2cms_pkg::OP_IDLE |-> dly_q != '0)
		else $error("phase timer empty while busy");

	// Finishing leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && done |=> op_q == i2cms_pkg::OP_IDLE)
		else $error("engine not idle after done");

	// ok only accompanies done
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		en && okv |-> done)
		else $error("ok without done");

	// Send byte starts in the SCL-low slot at phase index zero
	a_send_slot: assert property (@(posedge clk) disable iff (!arst_n)
		op_q == i2cms_pkg::OP_SEND && k_q == 5'd0 |-> slot_q == i2cms_pkg::SLOT_SCL_LOW)
		else $error("send slot out of step");

endmodule

@@ tb/tb_i2c_master_bit_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer
// Self-checking bench for the I2C master bit sequencer. Bus-cycle
// transactions are queued by a stimulus process and sent by a clocked driver
// with random gaps. A clocked monitor predicts the pin levels, busy, done,
// ok and the received byte for every accepted cycle and checks each result
// transaction. The run covers directed primitives, random bus transfers and
// several phase lengths, the zero and full-scale values among them.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer;

	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_PRINTED  = 40;
	// Outcome forced on the two start checks
	localparam int START_OK       = 0;
	localparam int START_BUS_BUSY = 1;
	localparam int START_NO_FALL  = 2;

	typedef struct {
		i2cms_pkg::op_t cmd;
		logic [7:0]     tx;
		logic           sda;
	} bus_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd       = 3'd0;
	logic [7:0]  tx_byte   = 8'd0;
	logic        sda_in    = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic        ok;
	logic [7:0]  rx_byte;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = 16'd0;

	i2c_master_bit_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.tx_byte   (tx_byte),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.ok        (ok),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Bookkeeping
	bus_item_t           pending_cycles[$];
	i2cms_pkg::result_t  expected_bus_state[$];
	int                  queued_count   = 0;
	int                  accepted_count = 0;
	int                  checked_count  = 0;
	int                  error_count    = 0;
	int                  cycle_count    = 0;
	int                  settings_used  = 0;
	logic [15:0]         gen_phase_len  = i2cms_pkg::PHASE_CYCLES_RST;

	// Predicted sequencer state
	i2cms_pkg::op_t      m_op;
	logic [4:0]          m_step;
	logic [15:0]         m_delay;
	logic [7:0]          m_shift;
	logic                m_scl;
	logic                m_sda;
	logic [7:0]          m_rx;
	logic                m_ack;
	logic [15:0]         m_phase_len;

	// Driver state
	bus_item_t           nxt;
	int                  in_gap   = 0;
	int                  out_gap  = 0;
	int                  in_calm  = 0;
	int                  out_calm = 0;
	i2cms_pkg::result_t  got_r;
	i2cms_pkg::result_t  want_r;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d expected %0d",
				checked_count, name, got, want));
	endtask

	function automatic int phases_of(input i2cms_pkg::op_t op);
		case (op)
			i2cms_pkg::OP_START: return 3;
			i2cms_pkg::OP_SEND:  return 24;
			i2cms_pkg::OP_READ:  return 16;
			default:             return 4;
		endcase
	endfunction

	// Pin action at the start of the current phase, then reload the delay
	task automatic enter_phase();
		case (m_op)
			i2cms_pkg::OP_START: begin
				if (m_step == 5'd0) begin
					m_scl = 1'b1;
					m_sda = 1'b1;
				end else
					m_sda = 1'b0;
			end
			i2cms_pkg::OP_STOP: begin
				case (m_step)
					5'd0: m_scl = 1'b0;
					5'd1: m_sda = 1'b0;
					5'd2: m_scl = 1'b1;
					default: m_sda = 1'b1;
				endcase
			end
			i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK, i2cms_pkg::OP_WAIT: begin
				case (m_step)
					5'd0: m_scl = 1'b0;
					5'd1: m_sda = (m_op == i2cms_pkg::OP_ACK) ? 1'b0 : 1'b1;
					5'd2: m_scl = 1'b1;
					default: m_scl = 1'b0;
				endcase
			end
			i2cms_pkg::OP_SEND: begin
				case (2'(m_step % 5'd3))
					i2cms_pkg::SLOT_SCL_LOW: m_scl = 1'b0;
					i2cms_pkg::SLOT_DATA: begin
						m_sda   = m_shift[7];
						m_shift = {m_shift[6:0], 1'b0};
					end
					default: m_scl = 1'b1;
				endcase
			end
			i2cms_pkg::OP_READ: begin
				if (m_step == 5'd0) begin
					m_sda = 1'b1;
					m_scl = 1'b0;
				end else
					m_scl = m_step[0];
			end
			default: ;
		endcase
		m_delay = (m_phase_len == 16'd0) ? 16'd1 : m_phase_len;
	endtask

	// One sequencer clock: command accept, phase timing, sampling, outputs
	task automatic sequencer_cycle(input i2cms_pkg::op_t c, input logic [7:0] txb,
			input logic sdai, output i2cms_pkg::result_t r);
		logic fin;
		logic okv;
		logic fail;
		fin  = 1'b0;
		okv  = 1'b0;
		fail = 1'b0;
		if (m_op == i2cms_pkg::OP_IDLE) begin
			if (c != i2cms_pkg::OP_IDLE) begin
				m_op    = c;
				m_step  = 5'd0;
				m_shift = (c == i2cms_pkg::OP_SEND) ? txb : 8'd0;
				m_ack   = 1'b0;
				enter_phase();
			end
		end else begin
			m_delay = m_delay - 16'd1;
			if (m_delay == 16'd0) begin
				if (m_op == i2cms_pkg::OP_START)
					fail = (m_step == 5'd0 && !sdai) || (m_step == 5'd1 && sdai);
				else if (m_op == i2cms_pkg::OP_WAIT && m_step == 5'd2)
					m_ack = !sdai;
				else if (m_op == i2cms_pkg::OP_READ && m_step[0])
					m_shift = {m_shift[6:0], sdai};
				if (fail) begin
					fin    = 1'b1;
					m_op   = i2cms_pkg::OP_IDLE;
					m_step = 5'd0;
				end else if (int'(m_step) + 1 >= phases_of(m_op)) begin
					fin = 1'b1;
					okv = (m_op == i2cms_pkg::OP_START) ||
						(m_op == i2cms_pkg::OP_WAIT && m_ack);
					if (m_op == i2cms_pkg::OP_SEND || m_op == i2cms_pkg::OP_READ)
						m_scl = 1'b0;
					if (m_op == i2cms_pkg::OP_READ)
						m_rx = m_shift;
					m_op   = i2cms_pkg::OP_IDLE;
					m_step = 5'd0;
				end else begin
					m_step = m_step + 5'd1;
					enter_phase();
				end
			end
		end
		r.scl  = m_scl;
		r.sda  = m_sda;
		r.busy = (m_op != i2cms_pkg::OP_IDLE);
		r.done = fin;
		r.ok   = okv;
		r.rx   = m_rx;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Stimulus helpers
	task automatic push_item(input i2cms_pkg::op_t c, input logic [7:0] txb,
			input logic sdai);
		bus_item_t it;
		it.cmd = c;
		it.tx  = txb;
		it.sda = sdai;
		pending_cycles.push_back(it);
		queued_count++;
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) push_item(i2cms_pkg::OP_IDLE, 8'($urandom), 1'($urandom));
	endtask

	// One primitive from accept to done. Busy cycles carry random commands,
	// which the block must ignore; SDA is forced only where it is sampled.
	task automatic run_prim(input i2cms_pkg::op_t op, input logic [7:0] txb, input int mode,
			input logic [7:0] levels);
		int pc;
		int end_c;
		int k;
		logic s;
		pc = (gen_phase_len == 16'd0) ? 1 : int'(gen_phase_len);
		if (op == i2cms_pkg::OP_START && mode == START_BUS_BUSY)
			end_c = pc;
		else if (op == i2cms_pkg::OP_START && mode == START_NO_FALL)
			end_c = 2 * pc;
		else
			end_c = phases_of(op) * pc;
		push_item(op, txb, 1'($urandom));
		for (int c = 1; c <= end_c; c++) begin
			s = 1'($urandom);
			if (c % pc == 0) begin
				k = c / pc - 1;
				if (op == i2cms_pkg::OP_START && k == 0)
					s = (mode != START_BUS_BUSY);
				else if (op == i2cms_pkg::OP_START && k == 1)
					s = (mode == START_NO_FALL);
				else if (op == i2cms_pkg::OP_WAIT && k == 2)
					s = levels[0];
				else if (op == i2cms_pkg::OP_READ && k % 2 == 1)
					s = levels[7 - (k - 1) / 2];
			end
			push_item(i2cms_pkg::op_t'($urandom_range(0, 7)), 8'($urandom), s);
		end
	endtask

	task automatic random_start();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			run_prim(i2cms_pkg::OP_START, 8'($urandom), START_OK, 8'd0);
		else if (r == 8)
			run_prim(i2cms_pkg::OP_START, 8'($urandom), START_BUS_BUSY, 8'd0);
		else
			run_prim(i2cms_pkg::OP_START, 8'($urandom), START_NO_FALL, 8'd0);
	endtask

	// Address, ACK poll, a few data bytes, stop
	task automatic bus_transfer();
		random_start();
		idle_cycles($urandom_range(0, 2));
		run_prim(i2cms_pkg::OP_SEND, 8'($urandom), START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_WAIT, 8'($urandom), START_OK, 8'($urandom));
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1)) begin
				run_prim(i2cms_pkg::OP_SEND, 8'($urandom), START_OK, 8'd0);
				run_prim(i2cms_pkg::OP_WAIT, 8'($urandom), START_OK, 8'($urandom));
			end else begin
				run_prim(i2cms_pkg::OP_READ, 8'($urandom), START_OK, 8'($urandom));
				run_prim($urandom_range(0, 1) ? i2cms_pkg::OP_ACK : i2cms_pkg::OP_NACK,
					8'($urandom), START_OK, 8'd0);
			end
			idle_cycles($urandom_range(0, 1));
		end
		run_prim(i2cms_pkg::OP_STOP, 8'($urandom), START_OK, 8'd0);
	endtask

	// Mostly whole transfers while plenty of budget is left, single primitives otherwise
	task automatic random_traffic(input int budget);
		int stop_at;
		int pc;
		stop_at = queued_count + budget;
		pc = (gen_phase_len == 16'd0) ? 1 : int'(gen_phase_len);
		while (queued_count < stop_at) begin
			if ($urandom_range(0, 3) != 0 && stop_at - queued_count >= 40 * pc)
				bus_transfer();
			else
				run_prim(i2cms_pkg::op_t'($urandom_range(1, 7)), 8'($urandom),
					$urandom_range(0, 2), 8'($urandom));
			idle_cycles($urandom_range(0, 3));
		end
	endtask

	// Everything queued has been accepted and checked, plus the pipeline
	task automatic wait_drained();
		while (accepted_count != queued_count || expected_bus_state.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_phase_len(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_phase_len = v;
		settings_used++;
		@(negedge clk);
	endtask

	// Reset and stimulus sequence
	initial begin
		logic [15:0] sched[7];
		sched = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4, 16'd2};
		sched[4] = 16'($urandom_range(1, 5));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset phase length: start with SDA held low, bus seen busy
		run_prim(i2cms_pkg::OP_START, 8'h00, START_BUS_BUSY, 8'd0);
		idle_cycles(3);
		wait_drained();

		// Directed primitives; zero phase length acts as a phase length of one
		write_phase_len(16'd0);
		run_prim(i2cms_pkg::OP_START, 8'h00, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_SEND, 8'h00, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_SEND, 8'hFF, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_WAIT, 8'h00, START_OK, 8'h00);
		run_prim(i2cms_pkg::OP_READ, 8'h00, START_OK, 8'hFF);
		run_prim(i2cms_pkg::OP_READ, 8'hFF, START_OK, 8'h00);
		run_prim(i2cms_pkg::OP_ACK, 8'h00, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_NACK, 8'h00, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_WAIT, 8'hFF, START_OK, 8'h01);
		run_prim(i2cms_pkg::OP_STOP, 8'h00, START_OK, 8'd0);
		idle_cycles(2);
		run_prim(i2cms_pkg::OP_START, 8'h00, START_BUS_BUSY, 8'd0);
		run_prim(i2cms_pkg::OP_START, 8'h00, START_NO_FALL, 8'd0);
		run_prim(i2cms_pkg::OP_READ, 8'h00, START_OK, 8'hA5);
		run_prim(i2cms_pkg::OP_SEND, 8'h5A, START_OK, 8'd0);
		run_prim(i2cms_pkg::OP_STOP, 8'h00, START_OK, 8'd0);
		idle_cycles(2);
		wait_drained();

		// Random transfers over several phase lengths
		foreach (sched[i]) begin
			write_phase_len(sched[i]);
			random_traffic(180);
			wait_drained();
		end

		// Full-scale phase length: the primitive stays busy to the end
		write_phase_len(16'hFFFF);
		push_item(i2cms_pkg::OP_WAIT, 8'($urandom), 1'($urandom));
		repeat (60)
			push_item(i2cms_pkg::op_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
		wait_drained();
		repeat (20) @(posedge clk);

		if (expected_bus_state.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_bus_state.size()));
		$display("Covered %0d bus cycles, %0d results checked, %0d phase length settings.",
			accepted_count, checked_count, settings_used);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Driver: input transactions from the pending queue, random output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (in_calm > 0)
				in_calm = in_calm - 1;
			else if ($urandom_range(0, 299) == 0)
				in_calm = $urandom_range(40, 160);
			if (out_calm > 0)
				out_calm = out_calm - 1;
			else if ($urandom_range(0, 299) == 0)
				out_calm = $urandom_range(40, 160);

			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_cycles.size() > 0) begin
					nxt = pending_cycles.pop_front();
					in_valid <= 1'b1;
					cmd      <= nxt.cmd;
					tx_byte  <= nxt.tx;
					sda_in   <= nxt.sda;
					in_gap = (in_calm > 0) ? 0 : pick_gap();
				end else
					in_valid <= 1'b0;
			end

			if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = (out_calm > 0) ? 0 : pick_gap();
			end
		end
	end

	// Monitor: check results first, then predict the cycle accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_op        = i2cms_pkg::OP_IDLE;
			m_step      = 5'd0;
			m_delay     = 16'd0;
			m_shift     = 8'd0;
			m_scl       = 1'b1;
			m_sda       = 1'b1;
			m_rx        = 8'd0;
			m_ack       = 1'b0;
			m_phase_len = i2cms_pkg::PHASE_CYCLES_RST;
		end else begin
			if (out_valid && out_ready) begin
				got_r = '{scl_out, sda_out, busy_res, done_res, ok, rx_byte};
				if (expected_bus_state.size() == 0)
					report_mismatch("result transaction with nothing expected");
				else begin
					want_r = expected_bus_state.pop_front();
					check_field("scl_out", got_r.scl, want_r.scl);
					check_field("sda_out", got_r.sda, want_r.sda);
					check_field("busy_res", got_r.busy, want_r.busy);
					check_field("done_res", got_r.done, want_r.done);
					check_field("ok", got_r.ok, want_r.ok);
					check_field("rx_byte", got_r.rx, want_r.rx);
				end
				checked_count++;
			end
			if (cfg_valid && cfg_ready)
				m_phase_len = cfg_data;
			if (in_valid && in_ready) begin
				sequencer_cycle(i2cms_pkg::op_t'(cmd), tx_byte, sda_in, want_r);
				expected_bus_state.push_back(want_r);
				accepted_count++;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending",
				cycle_count, expected_bus_state.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
